>>> design/mcfc_pkg.sv
`timescale 1ns / 1ps

package mcfc_pkg;

	// field widths
	localparam int AXIS_W  = 16;
	localparam int FMT_W   = 5;
	localparam int LCNT_W  = 5;
	localparam int TB_W    = 5;
	localparam int LVL_W   = 6;
	localparam int IDX_W   = 4;
	localparam int OFS_W   = 64;
	localparam int ALM_W   = 4;

	// stream payload widths, padded to whole bytes
	localparam int DIN_W   = 80;
	localparam int DOUT_W  = 264;

	// classified request handed from the front to the back
	typedef struct packed {
		logic [AXIS_W-1:0] width;
		logic [AXIS_W-1:0] height;
		logic [AXIS_W-1:0] depth;
		logic [AXIS_W-1:0] layers;
		logic [TB_W-1:0]   texel_bytes;
		logic [LVL_W-1:0]  levels;
		logic [ALM_W-1:0]  align_m1;
		logic              empty;
	} req_t;

endpackage

>>> design/mcfc_front.sv
`timescale 1ns / 1ps

module mcfc_front #(
	parameter int MAX_LEVELS = 16
) (
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [mcfc_pkg::DIN_W-1:0] s_axis_tdata,
	input  logic                       q_full,
	output logic                       q_push,
	output mcfc_pkg::req_t             q_req
);

	localparam logic [mcfc_pkg::LVL_W-1:0] MaxLv = mcfc_pkg::LVL_W'(MAX_LEVELS);

	logic [mcfc_pkg::FMT_W-1:0]  fmt;
	logic [mcfc_pkg::LCNT_W-1:0] lcnt;
	logic [mcfc_pkg::LVL_W-1:0]  lcnt_ext;
	logic [mcfc_pkg::TB_W-1:0]   tb;

	// texel size per format code
	function automatic logic [mcfc_pkg::TB_W-1:0] texel_bytes_of(
		input logic [mcfc_pkg::FMT_W-1:0] f);
		logic [mcfc_pkg::TB_W-1:0] r;
		case (f)
			5'd3: r = 5'd1;
			5'd4, 5'd5: r = 5'd2;
			5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd14, 5'd15: r = 5'd4;
			5'd13, 5'd16, 5'd17: r = 5'd8;
			5'd18: r = 5'd12;
			5'd19: r = 5'd16;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// unpack and classify the request
	always_comb begin
		fmt      = s_axis_tdata[52:48];
		lcnt     = s_axis_tdata[57:53];
		lcnt_ext = {1'b0, lcnt};
		tb       = texel_bytes_of(fmt);
		q_req.width       = s_axis_tdata[15:0];
		q_req.height      = s_axis_tdata[31:16];
		q_req.depth       = s_axis_tdata[47:32];
		q_req.layers      = s_axis_tdata[73:58];
		q_req.texel_bytes = tb;
		q_req.levels      = (lcnt_ext > MaxLv) ? MaxLv : lcnt_ext;
		q_req.empty       = (tb == '0) || (lcnt == '0) || (s_axis_tdata[73:58] == '0);
		// staging alignment minus one: 4, 8 or 16 bytes
		if (tb > 5'd8) begin
			q_req.align_m1 = 4'd15;
		end else if (tb > 5'd4) begin
			q_req.align_m1 = 4'd7;
		end else begin
			q_req.align_m1 = 4'd3;
		end
	end

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

endmodule

>>> design/mcfc_queue.sv
`timescale 1ns / 1ps

module mcfc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mcfc_pkg::req_t push_req,
	output logic           full,
	input  logic           pop,
	output logic           avail,
	output mcfc_pkg::req_t pop_req
);

	mcfc_pkg::req_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full    = (count_q == 2'd2);
	assign avail   = (count_q != 2'd0);
	assign pop_req = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_req;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != 2'd2) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0) else $error("queue pop while empty");

endmodule

>>> design/mcfc_back.sv
`timescale 1ns / 1ps

module mcfc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_avail,
	input  mcfc_pkg::req_t              q_req,
	output logic                        q_pop,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [mcfc_pkg::DOUT_W-1:0] m_axis_tdata,
	output logic                        m_axis_tuser,
	output logic                        m_axis_tlast
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL1  = 5'b00010,
		ST_MUL2  = 5'b00100,
		ST_SCALE = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t                          state_q;
	mcfc_pkg::req_t                  req_q;
	logic [mcfc_pkg::LVL_W-1:0]      lv_q;
	logic [mcfc_pkg::OFS_W-1:0]      src_q;
	logic [mcfc_pkg::OFS_W-1:0]      stg_q;
	logic [mcfc_pkg::OFS_W-1:0]      aligned_q;
	logic [mcfc_pkg::AXIS_W-1:0]     lw_q;
	logic [mcfc_pkg::AXIS_W-1:0]     lh_q;
	logic [mcfc_pkg::AXIS_W-1:0]     ld_q;
	logic [31:0]                     m1_q;
	logic [31:0]                     m2_q;
	logic [mcfc_pkg::OFS_W-1:0]      m3_q;
	logic [mcfc_pkg::OFS_W-1:0]      size_q;

	// output register
	logic                            out_valid_q;
	logic                            out_status_q;
	logic                            out_last_q;
	logic [mcfc_pkg::IDX_W-1:0]      out_idx_q;
	logic [mcfc_pkg::AXIS_W-1:0]     out_w_q;
	logic [mcfc_pkg::AXIS_W-1:0]     out_h_q;
	logic [mcfc_pkg::AXIS_W-1:0]     out_d_q;
	logic [mcfc_pkg::AXIS_W-1:0]     out_layers_q;
	logic [mcfc_pkg::OFS_W-1:0]      out_packed_q;
	logic [mcfc_pkg::OFS_W-1:0]      out_aligned_q;
	logic [mcfc_pkg::OFS_W-1:0]      out_size_q;

	logic                            out_free;
	logic                            load_out;
	logic                            is_last;
	logic [mcfc_pkg::AXIS_W-1:0]     lw_c;
	logic [mcfc_pkg::AXIS_W-1:0]     lh_c;
	logic [mcfc_pkg::AXIS_W-1:0]     ld_c;
	logic [mcfc_pkg::OFS_W-1:0]      mask;

	// axis extent at a level, floored at 1
	function automatic logic [mcfc_pkg::AXIS_W-1:0] axis_at(
		input logic [mcfc_pkg::AXIS_W-1:0] base,
		input logic [mcfc_pkg::LVL_W-1:0]  lv);
		logic [mcfc_pkg::AXIS_W-1:0] v;
		v = base >> lv;
		return (v == '0) ? mcfc_pkg::AXIS_W'(1) : v;
	endfunction

	// product by texel bytes as a sum of shifted copies
	function automatic logic [mcfc_pkg::OFS_W-1:0] scale_tb(
		input logic [mcfc_pkg::OFS_W-1:0] m,
		input logic [mcfc_pkg::TB_W-1:0]  tb);
		logic [mcfc_pkg::OFS_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < mcfc_pkg::TB_W; i++) begin
			if (tb[i]) begin
				acc = acc + (m << i);
			end
		end
		return acc;
	endfunction

	assign q_pop    = (state_q == ST_IDLE) && q_avail;
	assign out_free = !out_valid_q || m_axis_tready;
	assign load_out = (state_q == ST_EMIT) && out_free;
	assign is_last  = req_q.empty || ((lv_q + mcfc_pkg::LVL_W'(1)) == req_q.levels);
	assign lw_c     = axis_at(req_q.width, lv_q);
	assign lh_c     = axis_at(req_q.height, lv_q);
	assign ld_c     = axis_at(req_q.depth, lv_q);
	assign mask     = {{(mcfc_pkg::OFS_W - mcfc_pkg::ALM_W){1'b0}}, req_q.align_m1};

	// level sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_avail) begin
						state_q <= q_req.empty ? ST_EMIT : ST_MUL1;
					end
				end
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						state_q <= is_last ? ST_IDLE : ST_MUL1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-level datapath: extents, chained products, offsets
	always_ff @(posedge clk) begin
		if (q_pop) begin
			req_q <= q_req;
			lv_q  <= '0;
			src_q <= '0;
			stg_q <= '0;
		end
		if (state_q == ST_MUL1) begin
			lw_q      <= lw_c;
			lh_q      <= lh_c;
			ld_q      <= ld_c;
			m1_q      <= 32'(lw_c) * 32'(lh_c);
			m2_q      <= 32'(ld_c) * 32'(req_q.layers);
			aligned_q <= (stg_q + mask) & ~mask;
		end
		if (state_q == ST_MUL2) begin
			m3_q <= 64'(m1_q) * 64'(m2_q);
		end
		if (state_q == ST_SCALE) begin
			size_q <= scale_tb(m3_q, req_q.texel_bytes);
		end
		if (load_out && !req_q.empty) begin
			src_q <= src_q + size_q;
			stg_q <= aligned_q + size_q;
			lv_q  <= lv_q + mcfc_pkg::LVL_W'(1);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= req_q.empty;
			out_last_q   <= is_last;
			if (req_q.empty) begin
				out_idx_q     <= '0;
				out_w_q       <= mcfc_pkg::AXIS_W'(1);
				out_h_q       <= mcfc_pkg::AXIS_W'(1);
				out_d_q       <= mcfc_pkg::AXIS_W'(1);
				out_layers_q  <= '0;
				out_packed_q  <= '0;
				out_aligned_q <= '0;
				out_size_q    <= '0;
			end else begin
				out_idx_q     <= lv_q[mcfc_pkg::IDX_W-1:0];
				out_w_q       <= lw_q;
				out_h_q       <= lh_q;
				out_d_q       <= ld_q;
				out_layers_q  <= req_q.layers;
				out_packed_q  <= src_q;
				out_aligned_q <= aligned_q;
				out_size_q    <= size_q;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {4'b0, out_size_q, out_aligned_q, out_packed_q, out_layers_q,
		out_d_q, out_h_q, out_w_q, out_idx_q};

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q) |-> out_last_q)
		else $error("empty result not marked last");
	a_level_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && !req_q.empty) |-> (lv_q < req_q.levels))
		else $error("level counter ran past the request");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> out_valid_q)
		else $error("pending result dropped");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == ST_MUL1 || state_q == ST_EMIT))
		else $error("request taken without starting work");

endmodule

>>> design/mip_chain_footprint_calc.sv
`timescale 1ns / 1ps

// Mip chain footprint calculator. Each request on s_axis gives a base extent,
// a format code, a level count and a layer count. The block returns one
// footprint per mip level on m_axis, in level order, with tlast on the final
// one: level extent, layer count, packed source offset, aligned staging offset
// and byte size, all offsets and sizes modulo 2^64. A request with no texel
// size, no levels or no layers returns one empty footprint flagged in tuser.
// After a request is accepted it leaves the queue; each level then passes
// through the two chained multiplier stages, the texel-size scaling and the
// result load with its offset update, while an empty request goes straight
// to the load of its empty footprint, and each footprint is delivered from
// the output register. A two-entry request queue lets new requests be taken
// while a chain is still being worked out.
module mip_chain_footprint_calc #(
	parameter int MAX_LEVELS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// base_width, base_height, base_depth, pixel_format, level_count,
	// layer_count, zero pad
	input  logic [mcfc_pkg::DIN_W-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// level_index, level_width, level_height, level_depth, layers_out,
	// packed_offset, aligned_offset, byte_size, zero pad
	output logic [mcfc_pkg::DOUT_W-1:0] m_axis_tdata,
	// status
	output logic                        m_axis_tuser,
	output logic                        m_axis_tlast
);

	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_avail;
	mcfc_pkg::req_t push_req;
	mcfc_pkg::req_t pop_req;

	// request classification
	mcfc_front #(
		.MAX_LEVELS(MAX_LEVELS)
	) u_front (
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_req        (push_req)
	);

	// request queue
	mcfc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_req(push_req),
		.full    (q_full),
		.pop     (q_pop),
		.avail   (q_avail),
		.pop_req (pop_req)
	);

	// per-level layout engine
	mcfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_avail      (q_avail),
		.q_req        (pop_req),
		.q_pop        (q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule
